// File: rtl/fau_pkg.sv
// Shared types, codes and constants for the USB audio feature unit.
// Used by the RTL modules, the checker and the testbench; depends on nothing.
package fau_pkg;

  localparam int unsigned SmpW     = 16;
  localparam int unsigned GainW    = 16;
  localparam int unsigned RespLenW = 2;
  localparam int unsigned RespValW = 24;
  localparam int unsigned EvtW     = 2;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned ChanW    = 2;

  // Item operations.
  typedef enum logic [1:0] {
    OP_REQUEST = 2'd0,
    OP_SPEAKER = 2'd1,
    OP_MIC     = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  // Register indexes on the configuration port.
  typedef enum logic [CfgIdxW-1:0] {
    REG_SPK_CHANNELS = 2'd0,
    REG_MIC_CHANNELS = 2'd1,
    REG_MAX_VOLUME   = 2'd2
  } cfg_idx_e;

  // Class request codes, request type byte in the upper half.
  localparam logic [15:0] REQ_SET_CUR    = 16'h2101;
  localparam logic [15:0] REQ_SET_IDLE   = 16'h210A;
  localparam logic [15:0] REQ_GET_CUR    = 16'hA181;
  localparam logic [15:0] REQ_GET_MIN    = 16'hA182;
  localparam logic [15:0] REQ_GET_MAX    = 16'hA183;
  localparam logic [15:0] REQ_GET_RES    = 16'hA184;
  localparam logic [15:0] REQ_SET_CUR_EP = 16'h2201;
  localparam logic [15:0] REQ_GET_CUR_EP = 16'hA281;

  // Entities, control selectors, the left channel and the mic endpoint.
  localparam logic [7:0] ENT_SPK_FU   = 8'd2;
  localparam logic [7:0] ENT_MIC_FU   = 8'd5;
  localparam logic [7:0] ENT_SELECTOR = 8'd6;
  localparam logic [7:0] SEL_MUTE     = 8'd1;
  localparam logic [7:0] SEL_VOLUME   = 8'd2;
  localparam logic [7:0] CH_LEFT      = 8'd1;
  localparam logic [7:0] EP_MIC       = 8'h84;

  // Speaker mute event codes.
  localparam logic [EvtW-1:0] EVT_NONE     = 2'd0;
  localparam logic [EvtW-1:0] EVT_MUTE_ON  = 2'd1;
  localparam logic [EvtW-1:0] EVT_MUTE_OFF = 2'd2;

  // Queue between front and back.
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = QPtrW + 1;

  // Output buffer in the back part.
  localparam int unsigned ObufDepth = 2;
  localparam int unsigned ObufPtrW  = $clog2(ObufDepth);
  localparam int unsigned ObufCntW  = ObufPtrW + 1;

  // Q12 gain arithmetic.
  localparam int unsigned ProdW     = SmpW + GainW + 1;
  localparam int unsigned RndW      = ProdW + 1;
  localparam int unsigned GainShift = 12;
  localparam int unsigned QW        = RndW - GainShift;
  localparam int          RoundAdd  = 2048;

  // Classified work handed from the front to the back.
  typedef struct packed {
    logic [RespLenW-1:0]    resp_len;
    logic [RespValW-1:0]    resp_val;
    logic [EvtW-1:0]        mute_evt;
    logic                   smp_valid;
    logic signed [SmpW-1:0] smp_l;
    logic signed [SmpW-1:0] smp_r;
    logic [GainW-1:0]       gain_l;
    logic [GainW-1:0]       gain_r;
  } fau_entry_t;

  // One finished result.
  typedef struct packed {
    logic [RespLenW-1:0]    resp_len;
    logic [RespValW-1:0]    resp_val;
    logic [EvtW-1:0]        mute_evt;
    logic                   smp_valid;
    logic signed [SmpW-1:0] out_l;
    logic signed [SmpW-1:0] out_r;
  } fau_result_t;

endpackage

// File: rtl/fau_front.sv
// Front part: configuration registers, control request decode and all unit state.
// Classifies each accepted item into a work entry. Depends on fau_pkg.
module fau_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [fau_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [fau_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  logic                           accept_i,
  input  logic [1:0]                     operation_i,
  input  logic [15:0]                    request_code_i,
  input  logic [7:0]                     channel_number_i,
  input  logic [7:0]                     control_selector_i,
  input  logic [7:0]                     endpoint_address_i,
  input  logic [7:0]                     entity_id_i,
  input  logic [15:0]                    request_value_i,
  input  logic                           mode_running_i,
  input  logic                           packet_start_i,
  input  logic signed [fau_pkg::SmpW-1:0] sample_left_i,
  input  logic signed [fau_pkg::SmpW-1:0] sample_right_i,
  output fau_pkg::fau_entry_t            entry_o
);
  import fau_pkg::*;

  localparam logic [ChanW-1:0] CH_STEREO = 2'd2;
  localparam logic [GainW-1:0] GAIN_UNITY = 16'd4096;
  localparam logic [RespLenW-1:0] LEN_NONE = 2'd0;
  localparam logic [RespLenW-1:0] LEN_ONE  = 2'd1;
  localparam logic [RespLenW-1:0] LEN_TWO  = 2'd2;
  localparam logic [RespLenW-1:0] LEN_RATE = 2'd3;

  logic [ChanW-1:0] spk_ch_q, mic_ch_q;
  logic [15:0]      max_vol_q;
  logic [GainW-1:0] spk_gain_l_q, spk_gain_l_d, spk_gain_r_q, spk_gain_r_d;
  logic [GainW-1:0] mic_gain_l_q, mic_gain_l_d, mic_gain_r_q, mic_gain_r_d;
  logic [GainW-1:0] pkt_gain_l_q, pkt_gain_l_d, pkt_gain_r_q, pkt_gain_r_d;
  logic [7:0]       spk_mute_q, spk_mute_d, mic_mute_q, mic_mute_d;
  logic [15:0]      spk_rate_q, spk_rate_d, mic_rate_q, mic_rate_d;

  logic             is_mic_ep, is_left, is_spk_ent, is_mic_ent;
  logic             spk_mute_hit, mic_mute_hit, vol_hit, sel_hit;
  logic [GainW-1:0] cur_gain_l, cur_gain_r, mic_use_l, mic_use_r;
  fau_entry_t       entry;

  assign is_mic_ep    = (endpoint_address_i == EP_MIC);
  assign is_left      = (channel_number_i == CH_LEFT);
  assign is_spk_ent   = (entity_id_i == ENT_SPK_FU);
  assign is_mic_ent   = (entity_id_i == ENT_MIC_FU);
  assign spk_mute_hit = is_spk_ent && (control_selector_i == SEL_MUTE);
  assign mic_mute_hit = is_mic_ent && (control_selector_i == SEL_MUTE);
  assign vol_hit      = (is_spk_ent || is_mic_ent) && (control_selector_i == SEL_VOLUME);
  assign sel_hit      = (entity_id_i == ENT_SELECTOR);
  assign cur_gain_l   = is_spk_ent ? spk_gain_l_q : mic_gain_l_q;
  assign cur_gain_r   = is_spk_ent ? spk_gain_r_q : mic_gain_r_q;
  assign mic_use_l    = (mic_mute_q != 8'd0) ? '0 : mic_gain_l_q;
  assign mic_use_r    = (mic_mute_q != 8'd0) ? '0 : mic_gain_r_q;

  always_comb begin
    entry        = '0;
    spk_gain_l_d = spk_gain_l_q;
    spk_gain_r_d = spk_gain_r_q;
    mic_gain_l_d = mic_gain_l_q;
    mic_gain_r_d = mic_gain_r_q;
    pkt_gain_l_d = pkt_gain_l_q;
    pkt_gain_r_d = pkt_gain_r_q;
    spk_mute_d   = spk_mute_q;
    mic_mute_d   = mic_mute_q;
    spk_rate_d   = spk_rate_q;
    mic_rate_d   = mic_rate_q;
    unique case (op_e'(operation_i))
      OP_REQUEST: begin
        priority if (request_code_i == REQ_SET_CUR_EP) begin
          if (mode_running_i) begin
            if (is_mic_ep) begin
              mic_rate_d = request_value_i;
            end else begin
              spk_rate_d = request_value_i;
            end
          end
        end else if (request_code_i == REQ_GET_CUR_EP) begin
          entry.resp_len = LEN_RATE;
          entry.resp_val = RespValW'(is_mic_ep ? mic_rate_q : spk_rate_q);
        end else if (spk_mute_hit) begin
          if (request_code_i == REQ_GET_CUR) begin
            entry.resp_len = LEN_ONE;
            entry.resp_val = RespValW'(spk_mute_q);
          end else if (request_code_i == REQ_SET_CUR) begin
            spk_mute_d     = request_value_i[7:0];
            entry.mute_evt = (request_value_i[7:0] == 8'd1) ? EVT_MUTE_ON : EVT_MUTE_OFF;
          end
        end else if (mic_mute_hit) begin
          if (request_code_i == REQ_GET_CUR) begin
            entry.resp_len = LEN_ONE;
            entry.resp_val = RespValW'(mic_mute_q);
          end else if (request_code_i == REQ_SET_CUR) begin
            mic_mute_d = request_value_i[7:0];
          end
        end else if (vol_hit) begin
          priority if (request_code_i == REQ_GET_MIN) begin
            entry.resp_len = LEN_TWO;
          end else if (request_code_i == REQ_GET_MAX) begin
            entry.resp_len = LEN_TWO;
            entry.resp_val = RespValW'(max_vol_q);
          end else if (request_code_i == REQ_GET_RES) begin
            entry.resp_len = LEN_TWO;
            entry.resp_val = RespValW'(1);
          end else if (request_code_i == REQ_GET_CUR) begin
            entry.resp_len = LEN_TWO;
            entry.resp_val = RespValW'(is_left ? cur_gain_l : cur_gain_r);
          end else if (request_code_i == REQ_SET_CUR) begin
            if (is_spk_ent) begin
              if (is_left) begin
                spk_gain_l_d = request_value_i;
              end else begin
                spk_gain_r_d = request_value_i;
              end
            end else begin
              if (is_left) begin
                mic_gain_l_d = request_value_i;
              end else begin
                mic_gain_r_d = request_value_i;
              end
            end
          end else begin
            entry.resp_len = LEN_NONE;
          end
        end else if (sel_hit) begin
          if (request_code_i == REQ_GET_CUR) begin
            entry.resp_len = LEN_ONE;
            entry.resp_val = RespValW'(1);
          end
        end else begin
          // Anything not understood gets a single zero byte; an idle request gets nothing.
          if (request_code_i != REQ_SET_IDLE) begin
            entry.resp_len = LEN_ONE;
          end
        end
      end
      OP_SPEAKER: begin
        if (mode_running_i) begin
          if (packet_start_i) begin
            pkt_gain_l_d = spk_gain_l_q;
            pkt_gain_r_d = spk_gain_r_q;
            if (spk_mute_q != 8'd0) begin
              spk_gain_l_d = '0;
              spk_gain_r_d = '0;
            end
          end
          entry.smp_valid = 1'b1;
          entry.smp_l     = sample_left_i;
          if (spk_ch_q == CH_STEREO) begin
            entry.gain_l = pkt_gain_l_d;
            entry.smp_r  = sample_right_i;
            entry.gain_r = pkt_gain_r_d;
          end else begin
            entry.gain_l = pkt_gain_r_d;
          end
        end
      end
      OP_MIC: begin
        if (mode_running_i) begin
          entry.smp_valid = 1'b1;
          entry.smp_l     = sample_left_i;
          entry.gain_l    = mic_use_l;
          if (mic_ch_q == CH_STEREO) begin
            entry.smp_r  = sample_right_i;
            entry.gain_r = mic_use_r;
          end
        end
      end
      OP_NONE: begin
        entry = '0;
      end
    endcase
  end

  assign entry_o = entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spk_ch_q     <= CH_STEREO;
      mic_ch_q     <= CH_STEREO;
      max_vol_q    <= GAIN_UNITY;
      spk_gain_l_q <= GAIN_UNITY;
      spk_gain_r_q <= GAIN_UNITY;
      mic_gain_l_q <= GAIN_UNITY;
      mic_gain_r_q <= GAIN_UNITY;
      pkt_gain_l_q <= '0;
      pkt_gain_r_q <= '0;
      spk_mute_q   <= '0;
      mic_mute_q   <= '0;
      spk_rate_q   <= '0;
      mic_rate_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          REG_SPK_CHANNELS: spk_ch_q  <= cfg_wdata_i[ChanW-1:0];
          REG_MIC_CHANNELS: mic_ch_q  <= cfg_wdata_i[ChanW-1:0];
          REG_MAX_VOLUME:   max_vol_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (accept_i) begin
        spk_gain_l_q <= spk_gain_l_d;
        spk_gain_r_q <= spk_gain_r_d;
        mic_gain_l_q <= mic_gain_l_d;
        mic_gain_r_q <= mic_gain_r_d;
        pkt_gain_l_q <= pkt_gain_l_d;
        pkt_gain_r_q <= pkt_gain_r_d;
        spk_mute_q   <= spk_mute_d;
        mic_mute_q   <= mic_mute_d;
        spk_rate_q   <= spk_rate_d;
        mic_rate_q   <= mic_rate_d;
      end
    end
  end

endmodule

// File: rtl/fau_queue.sv
// Short queue of work entries between the front and the back.
// Depends on fau_pkg for the entry type and depth.
module fau_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  fau_pkg::fau_entry_t wdata_i,
  input  logic                rd_en_i,
  output fau_pkg::fau_entry_t rdata_o,
  output logic                full_o,
  output logic                empty_o
);
  import fau_pkg::*;

  fau_entry_t       mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_wr, do_rd;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_en_i && !full_o;
  assign do_rd   = rd_en_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      cnt_q <= cnt_q + QCntW'(do_wr) - QCntW'(do_rd);
    end
  end

endmodule

// File: rtl/fau_back.sv
// Back part: per-channel Q12 multiply, rounding and saturation, and the result buffer.
// Depends on fau_pkg for entry, result types and arithmetic widths.
module fau_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_empty_i,
  input  fau_pkg::fau_entry_t  q_data_i,
  output logic                 q_pop_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output fau_pkg::fau_result_t result_o
);
  import fau_pkg::*;

  typedef struct packed {
    logic [RespLenW-1:0]     resp_len;
    logic [RespValW-1:0]     resp_val;
    logic [EvtW-1:0]         mute_evt;
    logic                    smp_valid;
    logic signed [ProdW-1:0] prod_l;
    logic signed [ProdW-1:0] prod_r;
  } stage_t;

  localparam logic signed [SmpW-1:0] SmpMax = {1'b0, {(SmpW-1){1'b1}}};
  localparam logic signed [SmpW-1:0] SmpMin = {1'b1, {(SmpW-1){1'b0}}};

  // Adds the rounding constant, floors by the Q12 shift and clips to 16 bits.
  function automatic logic signed [SmpW-1:0] round_sat(input logic signed [ProdW-1:0] p);
    logic signed [RndW-1:0] r;
    logic signed [QW-1:0]   q;
    r = RndW'(p) + RndW'(RoundAdd);
    q = r[RndW-1:GainShift];
    if (q > QW'(SmpMax)) begin
      return SmpMax;
    end else if (q < QW'(SmpMin)) begin
      return SmpMin;
    end
    return q[SmpW-1:0];
  endfunction

  stage_t              s1_q, s1_d;
  logic                s1_v_q;
  fau_result_t         obuf_q [ObufDepth];
  fau_result_t         res_d;
  logic [ObufPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [ObufCntW-1:0] cnt_q;
  logic                obuf_room, s1_adv, q_pop, obuf_rd;

  assign obuf_room = (cnt_q != ObufCntW'(ObufDepth));
  assign s1_adv    = s1_v_q && obuf_room;
  assign q_pop     = !q_empty_i && (!s1_v_q || obuf_room);
  assign obuf_rd   = pop_i && !empty_o;
  assign q_pop_o   = q_pop;
  assign empty_o   = (cnt_q == '0);
  assign result_o  = obuf_q[rd_ptr_q];

  always_comb begin
    s1_d.resp_len  = q_data_i.resp_len;
    s1_d.resp_val  = q_data_i.resp_val;
    s1_d.mute_evt  = q_data_i.mute_evt;
    s1_d.smp_valid = q_data_i.smp_valid;
    s1_d.prod_l    = ProdW'($signed(q_data_i.smp_l))
                   * ProdW'($signed({1'b0, q_data_i.gain_l}));
    s1_d.prod_r    = ProdW'($signed(q_data_i.smp_r))
                   * ProdW'($signed({1'b0, q_data_i.gain_r}));
  end

  always_comb begin
    res_d.resp_len  = s1_q.resp_len;
    res_d.resp_val  = s1_q.resp_val;
    res_d.mute_evt  = s1_q.mute_evt;
    res_d.smp_valid = s1_q.smp_valid;
    res_d.out_l     = round_sat(s1_q.prod_l);
    res_d.out_r     = round_sat(s1_q.prod_r);
  end

  always_ff @(posedge clk_i) begin
    if (q_pop) begin
      s1_q <= s1_d;
    end
    if (s1_adv) begin
      obuf_q[wr_ptr_q] <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q   <= 1'b0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (q_pop) begin
        s1_v_q <= 1'b1;
      end else if (s1_adv) begin
        s1_v_q <= 1'b0;
      end
      if (s1_adv) begin
        wr_ptr_q <= wr_ptr_q + ObufPtrW'(1);
      end
      if (obuf_rd) begin
        rd_ptr_q <= rd_ptr_q + ObufPtrW'(1);
      end
      cnt_q <= cnt_q + ObufCntW'(s1_adv) - ObufCntW'(obuf_rd);
    end
  end

endmodule

// File: rtl/usb_audio_feature_unit.sv
// USB audio feature unit top level: front decode, work queue, back multiply and buffer.
// An accepted item passes the work queue, the product register and the result buffer.
// One item per cycle while full_o is low, set by the single registered multiply per channel.
// Reset (rst_ni, asynchronous, active low) empties both queues, sets the volume gains to
// unity, clears mute flags, rates and packet gains, and restores the registers.
module usb_audio_feature_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration write port.
  input  logic                             cfg_we_i,
  input  logic [fau_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [fau_pkg::CfgDataW-1:0]     cfg_wdata_i,
  // Item side.
  input  logic                             push_i,
  output logic                             full_o,
  input  logic [1:0]                       operation_i,
  input  logic [15:0]                      request_code_i,
  input  logic [7:0]                       channel_number_i,
  input  logic [7:0]                       control_selector_i,
  input  logic [7:0]                       endpoint_address_i,
  input  logic [7:0]                       entity_id_i,
  input  logic [15:0]                      request_value_i,
  input  logic                             mode_running_i,
  input  logic                             packet_start_i,
  input  logic signed [fau_pkg::SmpW-1:0]  sample_left_i,
  input  logic signed [fau_pkg::SmpW-1:0]  sample_right_i,
  // Result side.
  output logic                             empty_o,
  input  logic                             pop_i,
  output logic [fau_pkg::RespLenW-1:0]     response_length_o,
  output logic [fau_pkg::RespValW-1:0]     response_value_o,
  output logic [fau_pkg::EvtW-1:0]         speaker_mute_event_o,
  output logic                             sample_valid_o,
  output logic signed [fau_pkg::SmpW-1:0]  sample_out_left_o,
  output logic signed [fau_pkg::SmpW-1:0]  sample_out_right_o
);
  import fau_pkg::*;

  fau_entry_t  entry, q_data;
  fau_result_t result;
  logic        accept, q_full, q_empty, q_pop;

  // An item transfer happens whenever push_i is high and the work queue has a free
  // slot. All unit state is updated in the front at that edge, so later items always
  // see the effect of earlier control requests regardless of back-end stalls.
  assign accept = push_i && !q_full;
  assign full_o = q_full;

  fau_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .accept_i           (accept),
    .operation_i        (operation_i),
    .request_code_i     (request_code_i),
    .channel_number_i   (channel_number_i),
    .control_selector_i (control_selector_i),
    .endpoint_address_i (endpoint_address_i),
    .entity_id_i        (entity_id_i),
    .request_value_i    (request_value_i),
    .mode_running_i     (mode_running_i),
    .packet_start_i     (packet_start_i),
    .sample_left_i      (sample_left_i),
    .sample_right_i     (sample_right_i),
    .entry_o            (entry)
  );

  // The queue absorbs short stalls on the result side while the front keeps
  // taking items.
  fau_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_en_i (accept),
    .wdata_i (entry),
    .rd_en_i (q_pop),
    .rdata_o (q_data),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // The back registers both products, then rounds and clips them into a
  // two-entry result buffer whose head drives the result ports.
  fau_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_data_i  (q_data),
    .q_pop_o   (q_pop),
    .pop_i     (pop_i),
    .empty_o   (empty_o),
    .result_o  (result)
  );

  assign response_length_o    = result.resp_len;
  assign response_value_o     = result.resp_val;
  assign speaker_mute_event_o = result.mute_evt;
  assign sample_valid_o       = result.smp_valid;
  assign sample_out_left_o    = result.out_l;
  assign sample_out_right_o   = result.out_r;

endmodule

// File: rtl/fau_checker.sv
// Port-level checks for the USB audio feature unit, bound to the top level.
// Depends on fau_pkg for widths and the mute event codes.
module fau_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          pop_i,
  input logic                          empty_o,
  input logic [fau_pkg::RespLenW-1:0]  response_length_o,
  input logic [fau_pkg::RespValW-1:0]  response_value_o,
  input logic [fau_pkg::EvtW-1:0]      speaker_mute_event_o,
  input logic                          sample_valid_o,
  input logic signed [fau_pkg::SmpW-1:0] sample_out_left_o,
  input logic signed [fau_pkg::SmpW-1:0] sample_out_right_o
);
  import fau_pkg::*;

  // A sample result never carries a control reply or a mute event.
  a_sample_no_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && sample_valid_o) |-> (response_length_o == '0 &&
                                      speaker_mute_event_o == EVT_NONE))
    else $error("sample result carries control fields");

  // A result without valid samples shows silent sample fields.
  a_idle_samples_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !sample_valid_o) |-> (sample_out_left_o == '0 &&
                                       sample_out_right_o == '0))
    else $error("non-sample result has nonzero sample fields");

  // A mute event comes from a SET request, which never replies.
  a_event_no_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && speaker_mute_event_o != EVT_NONE) |->
      (response_length_o == '0 && (speaker_mute_event_o == EVT_MUTE_ON ||
                                   speaker_mute_event_o == EVT_MUTE_OFF)))
    else $error("mute event result is malformed");

  // A result that is not taken stays on the ports unchanged.
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pop_i) |=> (!empty_o && $stable(response_value_o) &&
                              $stable(sample_out_left_o) && $stable(sample_out_right_o)))
    else $error("waiting result changed before transfer");

endmodule

bind usb_audio_feature_unit fau_checker u_fau_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .pop_i                (pop_i),
  .empty_o              (empty_o),
  .response_length_o    (response_length_o),
  .response_value_o     (response_value_o),
  .speaker_mute_event_o (speaker_mute_event_o),
  .sample_valid_o       (sample_valid_o),
  .sample_out_left_o    (sample_out_left_o),
  .sample_out_right_o   (sample_out_right_o)
);

// File: test/tb.sv
// Self-checking testbench for usb_audio_feature_unit: directed rows, then random traffic.
// Depends on rtl/fau_pkg.sv and rtl/usb_audio_feature_unit.sv; reads no files.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fau_pkg::*;

  // Right channel code; any value other than the left one selects it.
  localparam logic [7:0] CH_RIGHT     = 8'd2;

  localparam logic [1:0]  STEREO      = 2'd2;
  localparam logic [15:0] UNITY_GAIN  = 16'd4096;
  localparam int          NUM_PHASES  = 7;
  localparam int          PHASE_ITEMS = 130;

  // One input item as the block sees it.
  typedef struct {
    logic [1:0]        op;
    logic [15:0]       code;
    logic [7:0]        chan;
    logic [7:0]        sel;
    logic [7:0]        ep;
    logic [7:0]        ent;
    logic [15:0]       val;
    logic              run;
    logic              pstart;
    logic signed [15:0] sl;
    logic signed [15:0] sr;
  } fau_item_t;

  // One row of the directed table; fixed_res marks a result typed in by hand.
  typedef struct {
    fau_item_t   it;
    bit          fixed_res;
    fau_result_t res;
  } plan_row_t;

  logic                   clk_i;
  logic                   rst_ni             = 1'b0;
  logic                   cfg_we_i           = 1'b0;
  logic [CfgIdxW-1:0]     cfg_idx_i          = '0;
  logic [CfgDataW-1:0]    cfg_wdata_i        = '0;
  logic                   push_i             = 1'b0;
  logic                   full_o;
  logic [1:0]             operation_i        = '0;
  logic [15:0]            request_code_i     = '0;
  logic [7:0]             channel_number_i   = '0;
  logic [7:0]             control_selector_i = '0;
  logic [7:0]             endpoint_address_i = '0;
  logic [7:0]             entity_id_i        = '0;
  logic [15:0]            request_value_i    = '0;
  logic                   mode_running_i     = 1'b0;
  logic                   packet_start_i     = 1'b0;
  logic signed [SmpW-1:0] sample_left_i      = '0;
  logic signed [SmpW-1:0] sample_right_i     = '0;
  logic                   empty_o;
  logic                   pop_i              = 1'b0;
  logic [RespLenW-1:0]    response_length_o;
  logic [RespValW-1:0]    response_value_o;
  logic [EvtW-1:0]        speaker_mute_event_o;
  logic                   sample_valid_o;
  logic signed [SmpW-1:0] sample_out_left_o;
  logic signed [SmpW-1:0] sample_out_right_o;

  usb_audio_feature_unit i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .push_i,
    .full_o,
    .operation_i,
    .request_code_i,
    .channel_number_i,
    .control_selector_i,
    .endpoint_address_i,
    .entity_id_i,
    .request_value_i,
    .mode_running_i,
    .packet_start_i,
    .sample_left_i,
    .sample_right_i,
    .empty_o,
    .pop_i,
    .response_length_o,
    .response_value_o,
    .speaker_mute_event_o,
    .sample_valid_o,
    .sample_out_left_o,
    .sample_out_right_o
  );

  // Shadow copy of the unit's state and registers, advanced once per accepted item.
  logic [1:0]  spk_chans, mic_chans;
  logic [15:0] max_vol_report;
  logic [15:0] spk_gain_l, spk_gain_r, mic_gain_l, mic_gain_r;
  logic [7:0]  spk_mute, mic_mute;
  logic [15:0] spk_rate, mic_rate;
  logic [15:0] pkt_gain_l, pkt_gain_r;

  // Results predicted for accepted items, oldest first.
  fau_result_t awaited_outputs[$];

  int errors      = 0;
  int n_requests  = 0;
  int n_speaker   = 0;
  int n_mic       = 0;
  int n_other     = 0;
  int n_checked   = 0;
  int n_settings  = 0;

  // Pacing state for both sides of the block.
  int send_burst  = 0;
  int pop_calm    = 0;
  int pop_hold    = 0;
  int pop_roll;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Generous fixed limit; a correct run takes a small fraction of this.
  initial begin
    #20_000_000;
    $display("** usb_audio_feature_unit: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Q12 gain: product plus half an LSB, floor shift by 12, clip to 16 bits signed.
  function automatic logic signed [15:0] q12_scale(logic signed [15:0] pcm, logic [15:0] gain);
    longint prod;
    prod = longint'(pcm) * longint'({48'd0, gain}) + 2048;
    prod = prod >>> 12;
    if (prod > 32767) prod = 32767;
    if (prod < -32768) prod = -32768;
    return prod[15:0];
  endfunction

  function automatic void reset_shadow();
    spk_chans      = STEREO;
    mic_chans      = STEREO;
    max_vol_report = UNITY_GAIN;
    spk_gain_l     = UNITY_GAIN;
    spk_gain_r     = UNITY_GAIN;
    mic_gain_l     = UNITY_GAIN;
    mic_gain_r     = UNITY_GAIN;
    spk_mute       = '0;
    mic_mute       = '0;
    spk_rate       = '0;
    mic_rate       = '0;
    pkt_gain_l     = '0;
    pkt_gain_r     = '0;
  endfunction

  // Works out the one result an accepted item causes and updates the shadow state.
  function automatic fau_result_t compute_unit_output(fau_item_t it);
    fau_result_t r;
    logic        is_mic;
    logic [15:0] cur_l, cur_r, gl, gr;
    r = '0;
    if (it.op == OP_REQUEST) begin
      is_mic = (it.ent == ENT_MIC_FU);
      if (it.code == REQ_SET_CUR_EP) begin
        // Endpoint rate only moves while the play mode runs.
        if (it.run) begin
          if (it.ep == EP_MIC) mic_rate = it.val;
          else spk_rate = it.val;
        end
      end else if (it.code == REQ_GET_CUR_EP) begin
        r.resp_len = 2'd3;
        r.resp_val = {8'd0, (it.ep == EP_MIC) ? mic_rate : spk_rate};
      end else if ((it.ent == ENT_SPK_FU || is_mic) && it.sel == SEL_MUTE) begin
        if (it.code == REQ_GET_CUR) begin
          r.resp_len = 2'd1;
          r.resp_val = {16'd0, is_mic ? mic_mute : spk_mute};
        end else if (it.code == REQ_SET_CUR) begin
          if (is_mic) begin
            mic_mute = it.val[7:0];
          end else begin
            spk_mute   = it.val[7:0];
            r.mute_evt = (spk_mute == 8'd1) ? EVT_MUTE_ON : EVT_MUTE_OFF;
          end
        end
      end else if ((it.ent == ENT_SPK_FU || is_mic) && it.sel == SEL_VOLUME) begin
        cur_l = is_mic ? mic_gain_l : spk_gain_l;
        cur_r = is_mic ? mic_gain_r : spk_gain_r;
        case (it.code)
          REQ_GET_MIN: begin
            r.resp_len = 2'd2;
          end
          REQ_GET_MAX: begin
            r.resp_len = 2'd2;
            r.resp_val = {8'd0, max_vol_report};
          end
          REQ_GET_RES: begin
            r.resp_len = 2'd2;
            r.resp_val = 24'd1;
          end
          REQ_GET_CUR: begin
            r.resp_len = 2'd2;
            r.resp_val = {8'd0, (it.chan == CH_LEFT) ? cur_l : cur_r};
          end
          REQ_SET_CUR: begin
            if (is_mic) begin
              if (it.chan == CH_LEFT) mic_gain_l = it.val;
              else mic_gain_r = it.val;
            end else begin
              if (it.chan == CH_LEFT) spk_gain_l = it.val;
              else spk_gain_r = it.val;
            end
          end
          default: ;
        endcase
      end else if (it.ent == ENT_SELECTOR) begin
        if (it.code == REQ_GET_CUR) begin
          r.resp_len = 2'd1;
          r.resp_val = 24'd1;
        end
      end else if (it.code != REQ_SET_IDLE) begin
        // Anything the unit does not recognize gets a single zero byte.
        r.resp_len = 2'd1;
      end
    end else if (it.op == OP_SPEAKER && it.run) begin
      // Packet gains latch at packet start; a muted speaker then loses its stored gains.
      if (it.pstart) begin
        pkt_gain_l = spk_gain_l;
        pkt_gain_r = spk_gain_r;
        if (spk_mute != 0) begin
          spk_gain_l = '0;
          spk_gain_r = '0;
        end
      end
      r.smp_valid = 1'b1;
      if (spk_chans == STEREO) begin
        r.out_l = q12_scale(it.sl, pkt_gain_l);
        r.out_r = q12_scale(it.sr, pkt_gain_r);
      end else begin
        r.out_l = q12_scale(it.sl, pkt_gain_r);
      end
    end else if (it.op == OP_MIC && it.run) begin
      gl = (mic_mute != 0) ? 16'd0 : mic_gain_l;
      gr = (mic_mute != 0) ? 16'd0 : mic_gain_r;
      r.smp_valid = 1'b1;
      r.out_l     = q12_scale(it.sl, gl);
      if (mic_chans == STEREO) r.out_r = q12_scale(it.sr, gr);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus construction
  // ---------------------------------------------------------------------------

  function automatic plan_row_t ctl_row(logic [15:0] code, logic [7:0] ent, logic [7:0] sel,
                                        logic [7:0] chan, logic [7:0] ep, logic [15:0] val,
                                        logic run);
    plan_row_t row;
    row.it           = '{default: '0};
    row.it.op        = OP_REQUEST;
    row.it.code      = code;
    row.it.ent       = ent;
    row.it.sel       = sel;
    row.it.chan      = chan;
    row.it.ep        = ep;
    row.it.val       = val;
    row.it.run       = run;
    row.fixed_res    = 1'b0;
    row.res          = '0;
    return row;
  endfunction

  function automatic plan_row_t pcm_row(logic [1:0] op, logic run, logic pstart,
                                        logic [15:0] sl, logic [15:0] sr);
    plan_row_t row;
    row.it        = '{default: '0};
    row.it.op     = op;
    row.it.run    = run;
    row.it.pstart = pstart;
    row.it.sl     = sl;
    row.it.sr     = sr;
    row.fixed_res = 1'b0;
    row.res       = '0;
    return row;
  endfunction

  // Marks a row whose control reply is obvious; sample fields stay zero.
  function automatic plan_row_t fixed(plan_row_t row, logic [1:0] len, logic [23:0] val,
                                      logic [EvtW-1:0] evt);
    row.fixed_res    = 1'b1;
    row.res          = '0;
    row.res.resp_len = len;
    row.res.resp_val = val;
    row.res.mute_evt = evt;
    return row;
  endfunction

  function automatic logic [15:0] pcm_value();
    case ($urandom_range(0, 9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] gain_value();
    case ($urandom_range(0, 7))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return UNITY_GAIN;
      3:       return 16'($urandom);
      default: return 16'($urandom_range(0, 8192));
    endcase
  endfunction

  function automatic logic [15:0] request_code_value();
    case ($urandom_range(0, 9))
      0:       return REQ_SET_CUR;
      1:       return REQ_SET_IDLE;
      2:       return REQ_GET_CUR;
      3:       return REQ_GET_MIN;
      4:       return REQ_GET_MAX;
      5:       return REQ_GET_RES;
      6:       return REQ_SET_CUR_EP;
      7:       return REQ_GET_CUR_EP;
      8:       return REQ_SET_CUR;
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly well-formed requests and live samples, with raw noise mixed in.
  function automatic fau_item_t random_item();
    fau_item_t   it;
    int unsigned roll;
    roll      = $urandom_range(0, 99);
    it.op     = (roll < 40) ? OP_REQUEST : (roll < 70) ? OP_SPEAKER :
                (roll < 95) ? OP_MIC : OP_NONE;
    it.run    = ($urandom_range(0, 9) != 0);
    it.pstart = ($urandom_range(0, 4) == 0);
    it.sl     = pcm_value();
    it.sr     = pcm_value();
    it.code   = request_code_value();
    roll      = $urandom_range(0, 99);
    it.ent    = (roll < 35) ? ENT_SPK_FU : (roll < 70) ? ENT_MIC_FU :
                (roll < 85) ? ENT_SELECTOR : 8'($urandom);
    roll      = $urandom_range(0, 99);
    it.sel    = (roll < 40) ? SEL_MUTE : (roll < 85) ? SEL_VOLUME : 8'($urandom);
    roll      = $urandom_range(0, 99);
    it.chan   = (roll < 45) ? CH_LEFT : (roll < 80) ? CH_RIGHT : 8'($urandom);
    it.ep     = ($urandom_range(0, 1) == 0) ? EP_MIC : 8'($urandom);
    if (it.sel == SEL_MUTE) begin
      // Mute values: off, on, and odd nonzero bytes that mute without a mute-on event.
      case ($urandom_range(0, 3))
        0:       it.val = {8'($urandom), 8'h00};
        1:       it.val = {8'($urandom), 8'h01};
        2:       it.val = 16'h0000;
        default: it.val = 16'($urandom);
      endcase
    end else begin
      it.val = gain_value();
    end
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Item side
  // ---------------------------------------------------------------------------

  // Starts at a rising edge and returns at the edge where the transfer happens.
  // The push is left high so that a following item can go out back to back.
  task automatic send_item(fau_item_t it, bit fixed_res, fau_result_t res);
    fau_result_t predicted;
    push_i             <= 1'b1;
    operation_i        <= it.op;
    request_code_i     <= it.code;
    channel_number_i   <= it.chan;
    control_selector_i <= it.sel;
    endpoint_address_i <= it.ep;
    entity_id_i        <= it.ent;
    request_value_i    <= it.val;
    mode_running_i     <= it.run;
    packet_start_i     <= it.pstart;
    sample_left_i      <= it.sl;
    sample_right_i     <= it.sr;
    do @(posedge clk_i); while (full_o);
    // The shadow state always advances; hand-typed rows only replace the prediction.
    predicted = compute_unit_output(it);
    awaited_outputs.push_back(fixed_res ? res : predicted);
    case (it.op)
      OP_REQUEST: n_requests++;
      OP_SPEAKER: n_speaker++;
      OP_MIC:     n_mic++;
      default:    n_other++;
    endcase
  endtask

  // Random sender idling: mostly none or short, sometimes long, with gap-free bursts.
  task automatic sender_gap();
    int unsigned roll;
    int unsigned gap;
    gap = 0;
    if (send_burst > 0) begin
      send_burst--;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 5) send_burst = $urandom_range(20, 80);
      else if (roll < 27) gap = $urandom_range(1, 3);
      else if (roll < 31) gap = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      push_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      REG_SPK_CHANNELS: spk_chans = data[1:0];
      REG_MIC_CHANNELS: mic_chans = data[1:0];
      REG_MAX_VOLUME:   max_vol_report = data;
      default: ;
    endcase
  endtask

  // Stops sending and waits until every predicted result has come back.
  task automatic drain_results();
    push_i <= 1'b0;
    while (awaited_outputs.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  task automatic compare_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  task automatic check_output();
    fau_result_t want;
    if (awaited_outputs.size() == 0) begin
      $error("result transfer with no item waiting for one");
      errors++;
    end else begin
      want = awaited_outputs.pop_front();
      n_checked++;
      compare_field("response_length", int'(want.resp_len), int'(response_length_o));
      compare_field("response_value", int'(want.resp_val), int'(response_value_o));
      compare_field("speaker_mute_event", int'(want.mute_evt), int'(speaker_mute_event_o));
      compare_field("sample_valid", int'(want.smp_valid), int'(sample_valid_o));
      compare_field("sample_out_left", int'(want.out_l), int'(sample_out_left_o));
      compare_field("sample_out_right", int'(want.out_r), int'(sample_out_right_o));
    end
  endtask

  // The receiver pops at random: short and long stalls, with stall-free stretches.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop_i && !empty_o) check_output();
      if (pop_calm > 0) begin
        pop_calm--;
        pop_i <= 1'b1;
      end else if (pop_hold > 0) begin
        pop_hold--;
        pop_i <= 1'b0;
      end else begin
        pop_i    <= 1'b1;
        pop_roll = $urandom_range(0, 99);
        if (pop_roll < 4) pop_calm = $urandom_range(20, 100);
        else if (pop_roll < 26) pop_hold = $urandom_range(1, 3);
        else if (pop_roll < 30) pop_hold = $urandom_range(10, 40);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    plan_row_t   plan[$];
    logic [1:0]  spk_setting [NUM_PHASES];
    logic [1:0]  mic_setting [NUM_PHASES];
    logic [15:0] max_setting;

    // Channel settings per phase; 0 and 3 are outside the documented range and act as mono.
    spk_setting = '{2'd2, 2'd1, 2'd0, 2'd2, 2'd3, 2'd1, 2'd2};
    mic_setting = '{2'd2, 2'd1, 2'd3, 2'd1, 2'd2, 2'd2, 2'd2};

    // Directed rows, run against the reset register values.
    // Reset replies: unity volume, the default max report, fixed min and resolution.
    plan.push_back(fixed(ctl_row(REQ_GET_CUR, ENT_SPK_FU, SEL_VOLUME, CH_LEFT, 8'h00, 16'h0, 1),
                         2'd2, 24'd4096, EVT_NONE));
    plan.push_back(fixed(ctl_row(REQ_GET_MIN, ENT_MIC_FU, SEL_VOLUME, CH_RIGHT, 8'h00, 16'h0, 1),
                         2'd2, 24'd0, EVT_NONE));
    plan.push_back(fixed(ctl_row(REQ_GET_MAX, ENT_SPK_FU, SEL_VOLUME, CH_LEFT, 8'h00, 16'h0, 1),
                         2'd2, 24'd4096, EVT_NONE));
    plan.push_back(fixed(ctl_row(REQ_GET_RES, ENT_MIC_FU, SEL_VOLUME, CH_LEFT, 8'h00, 16'h0, 1),
                         2'd2, 24'd1, EVT_NONE));
    // Endpoint rates: read at reset, written while running, write ignored while stopped.
    plan.push_back(fixed(ctl_row(REQ_GET_CUR_EP, 8'h00, 8'h00, 8'h00, EP_MIC, 16'h0, 1),
                         2'd3, 24'd0, EVT_NONE));
    plan.push_back(fixed(ctl_row(REQ_SET_CUR_EP, 8'h00, 8'h00, 8'h00, EP_MIC, 16'hFFFF, 1),
                         2'd0, 24'd0, EVT_NONE));
    plan.push_back(fixed(ctl_row(REQ_SET_CUR_EP, 8'h00, 8'h00, 8'h00, 8'h01, 16'hBB80, 0),
                         2'd0, 24'd0, EVT_NONE));
    plan.push_back(fixed(ctl_row(REQ_GET_CUR_EP, 8'h00, 8'h00, 8'h00, EP_MIC, 16'h0, 1),
                         2'd3, 24'h00FFFF, EVT_NONE));
    plan.push_back(fixed(ctl_row(REQ_GET_CUR_EP, 8'h00, 8'h00, 8'h00, 8'hFF, 16'h0, 1),
                         2'd3, 24'd0, EVT_NONE));
    // Selector unit, idle request, unknown request, unknown code on a matched control.
    plan.push_back(fixed(ctl_row(REQ_GET_CUR, ENT_SELECTOR, 8'hFF, 8'hFF, 8'hFF, 16'h0, 1),
                         2'd1, 24'd1, EVT_NONE));
    plan.push_back(fixed(ctl_row(REQ_SET_IDLE, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0, 1),
                         2'd0, 24'd0, EVT_NONE));
    plan.push_back(fixed(ctl_row(16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 1),
                         2'd1, 24'd0, EVT_NONE));
    plan.push_back(fixed(ctl_row(16'h0000, ENT_SPK_FU, SEL_MUTE, 8'h00, 8'h00, 16'h0, 1),
                         2'd0, 24'd0, EVT_NONE));
    // Full-scale speaker samples at unity, then a right gain of 0xFFFF that only
    // applies from the next packet start on, where it saturates.
    plan.push_back(pcm_row(OP_SPEAKER, 1, 1, 16'h7FFF, 16'h8000));
    plan.push_back(fixed(ctl_row(REQ_SET_CUR, ENT_SPK_FU, SEL_VOLUME, CH_RIGHT, 8'h00,
                                 16'hFFFF, 1), 2'd0, 24'd0, EVT_NONE));
    plan.push_back(pcm_row(OP_SPEAKER, 1, 0, 16'h0001, 16'hFFFF));
    plan.push_back(pcm_row(OP_SPEAKER, 1, 1, 16'h7FFF, 16'h8000));
    // Speaker mute: the next packet still plays, the one after is silent.
    plan.push_back(fixed(ctl_row(REQ_SET_CUR, ENT_SPK_FU, SEL_MUTE, 8'h00, 8'h00, 16'h0001, 1),
                         2'd0, 24'd0, EVT_MUTE_ON));
    plan.push_back(fixed(ctl_row(REQ_GET_CUR, ENT_SPK_FU, SEL_MUTE, 8'h00, 8'h00, 16'h0, 1),
                         2'd1, 24'd1, EVT_NONE));
    plan.push_back(pcm_row(OP_SPEAKER, 1, 1, 16'h1234, 16'hEDCC));
    plan.push_back(pcm_row(OP_SPEAKER, 1, 1, 16'h7FFF, 16'h8000));
    plan.push_back(fixed(ctl_row(REQ_SET_CUR, ENT_SPK_FU, SEL_MUTE, 8'h00, 8'h00, 16'h0100, 1),
                         2'd0, 24'd0, EVT_MUTE_OFF));
    // Mic mute zeroes the gain; unmuted, -1 rounds down to -1 and full scale holds.
    plan.push_back(pcm_row(OP_MIC, 1, 0, 16'h7FFF, 16'h7FFF));
    plan.push_back(ctl_row(REQ_SET_CUR, ENT_MIC_FU, SEL_MUTE, 8'h00, 8'h00, 16'h00FE, 1));
    plan.push_back(pcm_row(OP_MIC, 1, 0, 16'h7FFF, 16'h7FFF));
    plan.push_back(ctl_row(REQ_SET_CUR, ENT_MIC_FU, SEL_MUTE, 8'h00, 8'h00, 16'h0000, 1));
    plan.push_back(pcm_row(OP_MIC, 1, 0, 16'hFFFF, 16'h8000));
    // Unused operation and a sample while stopped both give an all-zero result.
    plan.push_back(fixed(pcm_row(OP_NONE, 1, 1, 16'h7FFF, 16'h7FFF), 2'd0, 24'd0, EVT_NONE));
    plan.push_back(fixed(pcm_row(OP_SPEAKER, 0, 1, 16'h7FFF, 16'h7FFF), 2'd0, 24'd0, EVT_NONE));

    reset_shadow();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[k]) begin
      send_item(plan[k].it, plan[k].fixed_res, plan[k].res);
      sender_gap();
    end

    // Random phases. Each one begins with the block drained, then rewrites every register.
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      case (p)
        0:       max_setting = 16'hFFFF;
        1:       max_setting = 16'h0000;
        3:       max_setting = 16'h0001;
        default: max_setting = 16'($urandom);
      endcase
      write_reg(REG_SPK_CHANNELS, {14'd0, spk_setting[p]});
      write_reg(REG_MIC_CHANNELS, {14'd0, mic_setting[p]});
      write_reg(REG_MAX_VOLUME, max_setting);
      cfg_we_i <= 1'b0;
      n_settings++;
      repeat (PHASE_ITEMS) begin
        send_item(random_item(), 1'b0, '0);
        sender_gap();
      end
    end

    drain_results();
    repeat (8) @(posedge clk_i);

    $display("Covered %0d control requests, %0d speaker and %0d mic samples, %0d other items.",
             n_requests, n_speaker, n_mic, n_other);
    $display("Ran %0d register settings after the directed rows; %0d results checked.",
             n_settings, n_checked);
    if (errors == 0 && awaited_outputs.size() == 0) begin
      $display("** usb_audio_feature_unit: PASSED **");
    end else begin
      $display("** usb_audio_feature_unit: FAILED **");
    end
    $finish;
  end

endmodule
